// ===== hdl/eyxy_pkg.sv =====
// shared types, constants and helpers for the y-x-y euler angle unit
// depends on nothing; used by every module in hdl
package eyxy_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int SQRT_STEPS    = 29;
  localparam int CW            = 33;  // cordic datapath width
  localparam int PI_Q13        = 25736;
  localparam int ONE_Q14       = 16384;

  localparam logic [1:0] KASE_GENERAL = 2'd0;
  localparam logic [1:0] KASE_LOWER   = 2'd1;
  localparam logic [1:0] KASE_UPPER   = 2'd2;

  localparam logic signed [CW-1:0] HALF_PI_Q29 = 33'sd843314857;

  localparam logic signed [CW-1:0] ATAN_Q29 [TABLE_LEN] = '{
    33'sd421657428, 33'sd248918915, 33'sd131521918, 33'sd66762579,
    33'sd33510843,  33'sd16771758,  33'sd8387925,   33'sd4194219,
    33'sd2097141,   33'sd1048575,   33'sd524288,    33'sd262144,
    33'sd131072,    33'sd65536,     33'sd32768,     33'sd16384,
    33'sd8192,      33'sd4096,      33'sd2048,      33'sd1024,
    33'sd512,       33'sd256,       33'sd128,       33'sd64
  };

  typedef struct packed {
    logic              valid;
    logic [1:0]        kase;
    logic signed [15:0] m11;
    logic signed [15:0] fy;
    logic signed [15:0] fx;
    logic signed [15:0] m10;
    logic signed [15:0] m12;
  } side_t;

  typedef struct packed {
    logic [57:0] v;
    logic [31:0] rem;
    logic [28:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kase;
  } ctl_t;

  function automatic logic signed [CW-1:0] scale_q14(input logic signed [15:0] m);
    logic signed [CW-1:0] t;
    t = CW'(m);
    return t <<< 14;
  endfunction

  // quadrant fold so the vectoring iterations start with x >= 0
  function automatic cordic_t cordic_entry(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
    cordic_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        c.x = y;
        c.y = -x;
        c.z = HALF_PI_Q29;
      end else begin
        c.x = -y;
        c.y = x;
        c.z = -HALF_PI_Q29;
      end
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  // 2^-29 rad to q3.13 with round half up, clamped to +-pi
  function automatic logic signed [15:0] round_angle(input cordic_t c);
    logic signed [CW:0] t;
    logic signed [15:0] r;
    t = (CW+1)'(c.z) + (CW+1)'(33'sd32768);
    t = t >>> 16;
    if (c.zero) r = '0;
    else if (t > PI_Q13) r = 16'(PI_Q13);
    else if (t < -PI_Q13) r = 16'(-PI_Q13);
    else r = t[15:0];
    return r;
  endfunction

endpackage

// ===== hdl/rotation_matrix_to_euler_yxy_unit.sv =====
// Y-X-Y euler angles from a rotation matrix: one matrix may be started every
// cycle (busy_o stays low) and its result passes the input register (loaded at
// the accepting edge), then 29 square-root cells, 16 cordic cells and the output
// register, which raises done_o.
// done_o is a one-cycle strobe and the receiver cannot stall it, so each transfer
// must be captured when it is shown. Depends on eyxy_pkg and the two cell modules.
module rotation_matrix_to_euler_yxy_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] m00_i,
  input  logic signed [15:0] m01_i,
  input  logic signed [15:0] m02_i,
  input  logic signed [15:0] m10_i,
  input  logic signed [15:0] m11_i,
  input  logic signed [15:0] m12_i,
  input  logic signed [15:0] m21_i,
  output logic               done_o,
  output logic signed [15:0] first_angle_o,
  output logic [14:0]        middle_angle_o,
  output logic signed [15:0] third_angle_o,
  output logic [1:0]         branch_case_o
);

  localparam int N = eyxy_pkg::CORDIC_STAGES;
  localparam int S = eyxy_pkg::SQRT_STEPS;

  eyxy_pkg::side_t side_d, side_q;
  logic [28:0]     w_d, w_q;
  logic [31:0]     sq11;

  eyxy_pkg::sqrt_t   sq_s   [0:S];
  eyxy_pkg::side_t   side_s [0:S];
  eyxy_pkg::cordic_t fc_s   [0:N];
  eyxy_pkg::cordic_t mc_s   [0:N];
  eyxy_pkg::cordic_t tc_s   [0:N];
  eyxy_pkg::ctl_t    ctl_s  [0:N];

  logic signed [15:0] fa, ma, ta;
  logic               done_q;
  logic signed [15:0] first_q, third_q;
  logic [14:0]        middle_q;
  logic [1:0]         kase_q;

  assign busy_o = 1'b0;

  always_comb begin
    sq11 = 32'(m11_i) * 32'(m11_i);
    side_d.valid = start_i && !busy_o;
    side_d.m11   = m11_i;
    side_d.m10   = m10_i;
    side_d.m12   = m12_i;
    w_d          = '0;
    if (m11_i <= -16'(eyxy_pkg::ONE_Q14)) begin
      side_d.kase = eyxy_pkg::KASE_LOWER;
      side_d.fy   = m02_i;
      side_d.fx   = m00_i;
    end else if (m11_i >= 16'(eyxy_pkg::ONE_Q14)) begin
      side_d.kase = eyxy_pkg::KASE_UPPER;
      side_d.fy   = m02_i;
      side_d.fx   = m00_i;
    end else begin
      side_d.kase = eyxy_pkg::KASE_GENERAL;
      side_d.fy   = m01_i;
      side_d.fx   = m21_i;
      w_d         = 29'(1 << 28) - sq11[28:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  // radicand is (1 - m11^2) << 28, 58 bits for 29 root digits
  assign sq_s[0]   = '{v: {1'b0, w_q, 28'b0}, rem: '0, root: '0};
  assign side_s[0] = side_q;

  for (genvar i = 0; i < S; i++) begin : g_sqrt
    eyxy_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sq_i   (sq_s[i]),
      .side_i (side_s[i]),
      .sq_o   (sq_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  assign fc_s[0] = eyxy_pkg::cordic_entry(eyxy_pkg::scale_q14(side_s[S].fy),
                                          eyxy_pkg::scale_q14(side_s[S].fx));
  assign tc_s[0] = eyxy_pkg::cordic_entry(eyxy_pkg::scale_q14(side_s[S].m10),
                                          -eyxy_pkg::scale_q14(side_s[S].m12));
  assign mc_s[0] = eyxy_pkg::cordic_entry(eyxy_pkg::CW'({1'b0, sq_s[S].root}),
                                          eyxy_pkg::scale_q14(side_s[S].m11));
  assign ctl_s[0] = '{valid: side_s[S].valid, kase: side_s[S].kase};

  for (genvar i = 0; i < N; i++) begin : g_cordic
    eyxy_cordic_cell u_first (
      .clk_i   (clk_i),
      .shift_i (5'(i)),
      .angle_i (eyxy_pkg::ATAN_Q29[i]),
      .cor_i   (fc_s[i]),
      .cor_o   (fc_s[i+1])
    );
    eyxy_cordic_cell u_middle (
      .clk_i   (clk_i),
      .shift_i (5'(i)),
      .angle_i (eyxy_pkg::ATAN_Q29[i]),
      .cor_i   (mc_s[i]),
      .cor_o   (mc_s[i+1])
    );
    eyxy_cordic_cell u_third (
      .clk_i   (clk_i),
      .shift_i (5'(i)),
      .angle_i (eyxy_pkg::ATAN_Q29[i]),
      .cor_i   (tc_s[i]),
      .cor_o   (tc_s[i+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_s[i+1] <= '0;
      end else begin
        ctl_s[i+1] <= ctl_s[i];
      end
    end
  end

  always_comb begin
    fa = eyxy_pkg::round_angle(fc_s[N]);
    ma = eyxy_pkg::round_angle(mc_s[N]);
    ta = eyxy_pkg::round_angle(tc_s[N]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      kase_q <= eyxy_pkg::KASE_GENERAL;
    end else begin
      done_q <= ctl_s[N].valid;
      kase_q <= ctl_s[N].kase;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_s[N].kase)
      eyxy_pkg::KASE_LOWER: begin
        first_q  <= -fa;
        middle_q <= 15'(eyxy_pkg::PI_Q13);
        third_q  <= '0;
      end
      eyxy_pkg::KASE_UPPER: begin
        first_q  <= fa;
        middle_q <= '0;
        third_q  <= '0;
      end
      default: begin
        first_q  <= fa;
        middle_q <= (ma < 0) ? 15'd0 : ma[14:0];
        third_q  <= ta;
      end
    endcase
  end

  assign done_o         = done_q;
  assign first_angle_o  = first_q;
  assign middle_angle_o = middle_q;
  assign third_angle_o  = third_q;
  assign branch_case_o  = kase_q;

endmodule

// ===== hdl/eyxy_sqrt_cell.sv =====
// one step of the digit-by-digit integer square root, two radicand bits per cell
// depends on eyxy_pkg
module eyxy_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  eyxy_pkg::sqrt_t sq_i,
  input  eyxy_pkg::side_t side_i,
  output eyxy_pkg::sqrt_t sq_o,
  output eyxy_pkg::side_t side_o
);

  eyxy_pkg::sqrt_t sq_d, sq_q;
  eyxy_pkg::side_t side_q;
  logic [31:0] acc;
  logic [31:0] trial;

  always_comb begin
    acc   = {sq_i.rem[29:0], sq_i.v[57:56]};
    trial = {1'b0, sq_i.root, 2'b01};
    sq_d.v = {sq_i.v[55:0], 2'b00};
    if (acc >= trial) begin
      sq_d.rem  = acc - trial;
      sq_d.root = {sq_i.root[27:0], 1'b1};
    end else begin
      sq_d.rem  = acc;
      sq_d.root = {sq_i.root[27:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  assign sq_o   = sq_q;
  assign side_o = side_q;

endmodule

// ===== hdl/eyxy_cordic_cell.sv =====
// one vectoring micro-rotation of the atan2 cordic
// depends on eyxy_pkg
module eyxy_cordic_cell (
  input  logic                               clk_i,
  input  logic [4:0]                         shift_i,
  input  logic signed [eyxy_pkg::CW-1:0]     angle_i,
  input  eyxy_pkg::cordic_t                  cor_i,
  output eyxy_pkg::cordic_t                  cor_o
);

  eyxy_pkg::cordic_t cor_d, cor_q;
  logic signed [eyxy_pkg::CW-1:0] xs, ys;

  always_comb begin
    xs = cor_i.x >>> shift_i;
    ys = cor_i.y >>> shift_i;
    cor_d.zero = cor_i.zero;
    if (cor_i.y >= 0) begin
      cor_d.x = cor_i.x + ys;
      cor_d.y = cor_i.y - xs;
      cor_d.z = cor_i.z + angle_i;
    end else begin
      cor_d.x = cor_i.x - ys;
      cor_d.y = cor_i.y + xs;
      cor_d.z = cor_i.z - angle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cor_q <= cor_d;
  end

  assign cor_o = cor_q;

endmodule

// ===== tb/rotation_matrix_to_euler_yxy_unit_tb.sv =====
// testbench for rotation_matrix_to_euler_yxy_unit: directed and random matrices,
// angles predicted by a bit-exact fixed-point cordic model in a scoreboard class
// depends on eyxy_pkg and the rtl in hdl
`timescale 1ns / 1ps

module rotation_matrix_to_euler_yxy_unit_tb;

  typedef struct {
    logic signed [15:0] first;
    logic [14:0]        middle;
    logic signed [15:0] third;
    logic [1:0]         kase;
  } angles_t;

  class euler_board;
    angles_t pending[$];
    int      errors;

    static function longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
    endfunction

    static function longint vec_atan2(longint y, longint x);
      longint z, nx, ny, t;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = eyxy_pkg::HALF_PI_Q29;
        end else begin
          t = x; x = -y; y = t; z = -eyxy_pkg::HALF_PI_Q29;
        end
      end
      for (int i = 0; i < eyxy_pkg::CORDIC_STAGES && i < eyxy_pkg::TABLE_LEN; i++) begin
        if (y >= 0) begin
          nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += eyxy_pkg::ATAN_Q29[i];
        end else begin
          nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= eyxy_pkg::ATAN_Q29[i];
        end
        x = nx; y = ny;
      end
      z = floor_shr(z + 32768, 16);
      if (z > eyxy_pkg::PI_Q13) z = eyxy_pkg::PI_Q13;
      if (z < -eyxy_pkg::PI_Q13) z = -eyxy_pkg::PI_Q13;
      return z;
    endfunction

    static function longint floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function void note_matrix(logic signed [15:0] m00, m01, m02, m10, m11, m12, m21);
      angles_t a;
      longint  sc, mid, s;
      sc = 16384;
      if (m11 <= -eyxy_pkg::ONE_Q14) begin
        a.kase = eyxy_pkg::KASE_LOWER; a.middle = 15'(eyxy_pkg::PI_Q13); a.third = '0;
        a.first = 16'(-vec_atan2(m02 * sc, m00 * sc));
      end else if (m11 >= eyxy_pkg::ONE_Q14) begin
        a.kase = eyxy_pkg::KASE_UPPER; a.middle = '0; a.third = '0;
        a.first = 16'(vec_atan2(m02 * sc, m00 * sc));
      end else begin
        s = floor_sqrt(longint'(eyxy_pkg::ONE_Q14 * eyxy_pkg::ONE_Q14
                                - longint'(m11) * m11) << 28);
        mid = vec_atan2(s, m11 * sc);
        if (mid < 0) mid = 0;
        a.kase = eyxy_pkg::KASE_GENERAL; a.middle = 15'(mid);
        a.first = 16'(vec_atan2(m01 * sc, m21 * sc));
        a.third = 16'(vec_atan2(m10 * sc, -m12 * sc));
      end
      pending.push_back(a);
    endfunction

    function void check_angles(angles_t got);
      angles_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result first=%0d", $time, got.first);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.first !== e.first) begin
        $display("%0t: first_angle exp %0d got %0d", $time, e.first, got.first); errors++;
      end
      if (got.middle !== e.middle) begin
        $display("%0t: middle_angle exp %0d got %0d", $time, e.middle, got.middle); errors++;
      end
      if (got.third !== e.third) begin
        $display("%0t: third_angle exp %0d got %0d", $time, e.third, got.third); errors++;
      end
      if (got.kase !== e.kase) begin
        $display("%0t: branch_case exp %0d got %0d", $time, e.kase, got.kase); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o;
  logic signed [15:0] m00_i = '0, m01_i = '0, m02_i = '0, m10_i = '0;
  logic signed [15:0] m11_i = '0, m12_i = '0, m21_i = '0;
  logic signed [15:0] first_angle_o, third_angle_o;
  logic [14:0]        middle_angle_o;
  logic [1:0]         branch_case_o;

  euler_board board = new();

  always #4 clk_i = ~clk_i;

  rotation_matrix_to_euler_yxy_unit dut (.*);

  always @(posedge clk_i) begin
    angles_t got;
    if (rst_ni && done_o) begin
      got.first = first_angle_o; got.middle = middle_angle_o;
      got.third = third_angle_o; got.kase = branch_case_o;
      board.check_angles(got);
    end
  end

  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'(16384);
      1: return -16'sd16384;
      2: return 16'($urandom);             // out of range too
      3: return '0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // one transfer; a random gap before it when gaps is set, start stays high on back-to-back items
  task automatic send_matrix(logic signed [15:0] a, b, c, d, e, f, g, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    m00_i <= a; m01_i <= b; m02_i <= c; m10_i <= d;
    m11_i <= e; m12_i <= f; m21_i <= g;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_matrix(a, b, c, d, e, f, g);
  endtask

  initial begin
    int waited;
    logic signed [15:0] mx, mn;
    mx = 16'sh7fff; mn = 16'sh8000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: poles, identity, zero operands, field extremes
    send_matrix(16384, 0, 0, 0, 16384, 0, 16384, 0);
    send_matrix(-16384, 0, 0, 0, -16384, 0, 16384, 0);
    send_matrix(0, 0, 0, 0, mx, 0, 0, 0);
    send_matrix(0, 0, 0, 0, mn, 0, 0, 0);
    send_matrix(mn, 5, 7, 0, -16384, 0, 0, 0);
    send_matrix(0, 0, 0, 0, 0, 0, 0, 0);
    send_matrix(0, 16384, 0, 16384, 0, 0, 0, 0);
    send_matrix(0, -16384, 0, -16384, 16383, 0, 0, 0);
    send_matrix(0, 0, 0, 0, -16383, 16384, -16384, 0);
    send_matrix(mx, mx, mx, mx, 100, mx, mx, 0);
    send_matrix(mn, mn, mn, mn, -100, mn, mn, 0);
    send_matrix(-16384, 1, 16384, 0, 16384, -1, 0, 0);
    send_matrix(-16384, 0, -1, 0, 16384, 0, -16384, 0);
    send_matrix(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh1555, 16'sh5555, 16'shaaaa, 0);
    for (int n = 0; n < 600; n++)
      send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                  rand_entry(), rand_entry(), rand_entry(), $urandom_range(0, 3) != 0);
    start_i <= 1'b0;
    waited = 0;
    while (board.pending.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("rotation_matrix_to_euler_yxy_unit test passed");
    else
      $display("rotation_matrix_to_euler_yxy_unit test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("rotation_matrix_to_euler_yxy_unit test failed");
    $finish;
  end

endmodule
